// File: rtl/lgge_pkg.sv
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared constants and command types of the life grid engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

    // Grid geometry
    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int ROW_AW    = $clog2(GRID_ROWS);
    localparam int COL_AW    = $clog2(GRID_COLS);
    localparam int CNT_W     = $clog2(GRID_ROWS + 1);

    // Field widths fixed by the interface
    localparam int KIND_W = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int CFG_W  = 7;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEP   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Classified operation
    typedef enum logic [1:0] {
        OP_TOGGLE,
        OP_READ,
        OP_STEP,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cmd;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Back end status for the top level
    typedef struct packed {
        logic idle;
        logic sweeping;
    } t_back_stat;

endpackage

// File: rtl/life_grid_generation_engine.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine
// Game of Life (B3/S23) grid engine with toggle, read and step commands.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries kind, row and col. A toggle
// inverts one cell, a read reports it, a step advances the region in use one
// generation. Each item gives exactly one result on the output channel
// (o_out_valid / i_out_stall): the cell value, or 0 for a step or an unused
// or off-grid item.
// A two-entry command queue parts the front from the back end, so up to two
// items are taken while the back end works or a result waits to be taken.
// A toggle or read passes through the queue and then the ACCESS and FIN
// states of the back end. A step reads one row per cycle through a
// three-row window over the row memory's single read port, and skips the
// sweep and goes straight to its result when the region is empty.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 is
// rows_in_use, index 1 is cols_in_use; write only while the block is idle.
// Synchronous reset empties the queue, drops any result and marks every row
// unwritten, so the grid reads all dead at once; no clearing pass is needed.
// While the receiver stalls, the result is held and the back end waits with
// its next result; the front keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module life_grid_generation_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lgge_pkg::KIND_W-1:0] i_kind,
    input  logic [lgge_pkg::ROW_W-1:0]  i_row,
    input  logic [lgge_pkg::COL_W-1:0]  i_col,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_cell_alive,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [lgge_pkg::CFG_W-1:0]  i_cfg_data
);

    logic [lgge_pkg::CFG_W-1:0] r_rows_in_use;
    logic [lgge_pkg::CFG_W-1:0] r_cols_in_use;
    lgge_pkg::t_q_head          head;
    lgge_pkg::t_back_stat       stat;
    logic                       pop;
    logic [lgge_pkg::Q_CW-1:0]  q_count;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= lgge_pkg::CFG_W'(64);
            r_cols_in_use <= lgge_pkg::CFG_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lgge_pkg::CFG_ROWS: r_rows_in_use <= i_cfg_data;
                lgge_pkg::CFG_COLS: r_cols_in_use <= i_cfg_data;
                default:            r_rows_in_use <= r_rows_in_use;
            endcase
        end
    end

    lgge_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_pop      (pop),
        .o_head     (head),
        .o_count    (q_count)
    );

    lgge_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rows_in_use (r_rows_in_use),
        .i_cols_in_use (r_cols_in_use),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_alive  (o_cell_alive),
        .o_stat        (stat)
    );

`ifndef SYNTH
    // Back end only takes a command when it is idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> stat.idle)
        else $error("command popped while back end busy");

    // Queue never holds more than its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(q_count) <= lgge_pkg::Q_DEPTH)
        else $error("command queue overfilled");

    // A sweep in progress leaves the queue alone
    a_sweep_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.sweeping |-> !pop)
        else $error("queue popped during sweep");

    // Reset drops any pending result
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

// File: rtl/lgge_front.sv
// ----------------------------------------------------------------------------
// lgge_front
// Accepts items, classifies them into operations and queues them.
// ----------------------------------------------------------------------------
module lgge_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [lgge_pkg::KIND_W-1:0] i_kind,
    input  logic [lgge_pkg::ROW_W-1:0]  i_row,
    input  logic [lgge_pkg::COL_W-1:0]  i_col,
    input  logic                       i_pop,
    output lgge_pkg::t_q_head          o_head,
    output logic [lgge_pkg::Q_CW-1:0]  o_count
);

    lgge_pkg::t_cmd            r_q [lgge_pkg::Q_DEPTH];
    logic [lgge_pkg::Q_PW-1:0] r_wptr;
    logic [lgge_pkg::Q_PW-1:0] r_rptr;
    logic [lgge_pkg::Q_CW-1:0] r_cnt;
    lgge_pkg::t_cmd            cls_cmd;
    logic                      on_grid;
    logic                      full;
    logic                      push;
    logic                      pop;

    // Classify the incoming item
    always_comb begin
        on_grid = (int'(i_row) < lgge_pkg::GRID_ROWS) &&
                  (int'(i_col) < lgge_pkg::GRID_COLS);
        cls_cmd.row = i_row;
        cls_cmd.col = i_col;
        case (i_kind)
            lgge_pkg::KIND_TOGGLE: cls_cmd.op = on_grid ? lgge_pkg::OP_TOGGLE : lgge_pkg::OP_NONE;
            lgge_pkg::KIND_READ:   cls_cmd.op = on_grid ? lgge_pkg::OP_READ : lgge_pkg::OP_NONE;
            lgge_pkg::KIND_STEP:   cls_cmd.op = lgge_pkg::OP_STEP;
            default:               cls_cmd.op = lgge_pkg::OP_NONE;
        endcase
    end

    assign full       = (r_cnt == lgge_pkg::Q_CW'(lgge_pkg::Q_DEPTH));
    assign o_in_stall = full;
    assign push       = i_in_valid && !full;
    assign pop        = i_pop && (r_cnt != '0);

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls_cmd;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (int'(r_wptr) == lgge_pkg::Q_DEPTH - 1) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (int'(r_rptr) == lgge_pkg::Q_DEPTH - 1) ? '0 : r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rptr];
    assign o_count      = r_cnt;

endmodule

// File: rtl/lgge_back.sv
// ----------------------------------------------------------------------------
// lgge_back
// Executes queued operations on the row memory and sweeps generations.
// ----------------------------------------------------------------------------
module lgge_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lgge_pkg::CFG_W-1:0] i_rows_in_use,
    input  logic [lgge_pkg::CFG_W-1:0] i_cols_in_use,
    input  lgge_pkg::t_q_head          i_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_cell_alive,
    output lgge_pkg::t_back_stat       o_stat
);

    localparam int W  = lgge_pkg::GRID_COLS;
    localparam int RA = lgge_pkg::ROW_AW;
    localparam int CW = lgge_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_FILL,
        S_SWEEP,
        S_FIN
    } t_state;

    t_state                 r_state;
    lgge_pkg::t_op          r_op;
    logic [lgge_pkg::COL_AW-1:0] r_col;
    logic [RA-1:0]          r_row;
    logic                   r_res;
    logic [CW-1:0]          r_nr;
    logic [CW-1:0]          r_idx;
    logic [W-1:0]           r_cmask;
    logic [W-1:0]           r_prev;
    logic [W-1:0]           r_cur;
    logic                   r_out_valid;
    logic                   r_out_alive;

    logic [W-1:0]           mem [lgge_pkg::GRID_ROWS];
    logic [lgge_pkg::GRID_ROWS-1:0] r_row_valid;
    logic [W-1:0]           r_rdata;
    logic                   r_rd_valid;

    logic [RA-1:0]          raddr;
    logic                   we;
    logic [RA-1:0]          waddr;
    logic [W-1:0]           wdata;
    logic [W-1:0]           row_data;
    logic [W-1:0]           next_row;
    logic [W-1:0]           life_row;
    logic [W-1:0]           cmask;
    logic [CW-1:0]          nr;
    logic [CW-1:0]          nc;
    logic [CW:0]            idx_p1;
    logic                   next_in;
    logic                   cell_bit;
    logic                   out_free;

    // B3/S23 on one row, neighbors masked to the columns in use
    function automatic logic [W-1:0] f_life(
        input logic [W-1:0] p,
        input logic [W-1:0] c,
        input logic [W-1:0] n,
        input logic [W-1:0] m
    );
        logic [W-1:0] pm, cm, nm;
        logic [W-1:0] pl, pr, cl, cr, nl, nrr;
        logic [3:0]   cnt;
        logic [W-1:0] res;
        pm  = p & m;
        cm  = c & m;
        nm  = n & m;
        pl  = pm << 1;
        pr  = pm >> 1;
        cl  = cm << 1;
        cr  = cm >> 1;
        nl  = nm << 1;
        nrr = nm >> 1;
        for (int k = 0; k < W; k++) begin
            cnt = 4'(pl[k]) + 4'(pm[k]) + 4'(pr[k]) + 4'(cl[k]) +
                  4'(cr[k]) + 4'(nl[k]) + 4'(nm[k]) + 4'(nrr[k]);
            res[k] = (cnt == 4'd3) || (cm[k] && (cnt == 4'd2));
        end
        return res;
    endfunction

    // Region size clamped to the grid, and the column mask
    always_comb begin
        nr = (int'(i_rows_in_use) > lgge_pkg::GRID_ROWS) ?
             CW'(lgge_pkg::GRID_ROWS) : CW'(i_rows_in_use);
        nc = (int'(i_cols_in_use) > lgge_pkg::GRID_COLS) ?
             CW'(lgge_pkg::GRID_COLS) : CW'(i_cols_in_use);
        for (int k = 0; k < W; k++) begin
            cmask[k] = (k < int'(nc));
        end
    end

    // Datapath: row data, sweep window and memory controls
    always_comb begin
        row_data = r_rd_valid ? r_rdata : '0;
        cell_bit = row_data[r_col];
        idx_p1   = {1'b0, r_idx} + 1'b1;
        next_in  = (idx_p1 < {1'b0, r_nr});
        next_row = next_in ? row_data : '0;
        life_row = f_life(r_prev, r_cur, next_row, r_cmask);
        out_free = !r_out_valid || !i_out_stall;

        raddr = '0;
        we    = 1'b0;
        waddr = r_row;
        wdata = row_data ^ (W'(1) << r_col);
        o_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop = i_head.valid;
                raddr = RA'(i_head.cmd.row);
            end
            S_ACCESS: begin
                we = (r_op == lgge_pkg::OP_TOGGLE);
            end
            S_FILL: begin
                raddr = RA'(1);
            end
            S_SWEEP: begin
                raddr = RA'(r_idx + CW'(2));
                we    = 1'b1;
                waddr = RA'(r_idx);
                wdata = (life_row & r_cmask) | (r_cur & ~r_cmask);
            end
            default: begin
                raddr = '0;
            end
        endcase
        if (r_state == S_IDLE && i_head.cmd.op == lgge_pkg::OP_STEP) begin
            raddr = '0;
        end
    end

    // Row memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata    <= mem[raddr];
        r_rd_valid <= r_row_valid[raddr];
    end

    // Per-row written flags: an unwritten row reads as all dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (we) begin
            r_row_valid[waddr] <= 1'b1;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Result valid: set as a result leaves FIN, cleared on transfer
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_op  <= i_head.cmd.op;
                        r_row <= RA'(i_head.cmd.row);
                        r_col <= lgge_pkg::COL_AW'(i_head.cmd.col);
                        r_nr  <= nr;
                        r_cmask <= cmask;
                        r_res <= 1'b0;
                        case (i_head.cmd.op)
                            lgge_pkg::OP_TOGGLE,
                            lgge_pkg::OP_READ: r_state <= S_ACCESS;
                            lgge_pkg::OP_STEP: begin
                                r_state <= (nr == '0 || nc == '0) ? S_FIN : S_FILL;
                            end
                            default:           r_state <= S_FIN;
                        endcase
                    end
                end
                S_ACCESS: begin
                    r_res   <= (r_op == lgge_pkg::OP_TOGGLE) ? !cell_bit : cell_bit;
                    r_state <= S_FIN;
                end
                S_FILL: begin
                    r_prev  <= '0;
                    r_cur   <= row_data;
                    r_idx   <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    r_prev <= r_cur;
                    r_cur  <= next_row;
                    r_idx  <= r_idx + 1'b1;
                    if (!next_in) begin
                        r_res   <= 1'b0;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_alive <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_alive    = r_out_alive;
    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.sweeping = (r_state == S_SWEEP) || (r_state == S_FILL);

endmodule
